/* rtl/vfdk_pkg.sv */
// ----------------------------------------------------------------------------
// vfdk_pkg: shared types and constants of the voice frame key detector
// Holds the signature masks, key table, register indexes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package vfdk_pkg;

    // Default command buffer capacity (capped at the store depth)
    localparam int MAX_DIGITS  = 16;
    localparam int STORE_DEPTH = 16;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Field widths
    localparam int HEAD_W   = 32;
    localparam int TAIL_W   = 40;
    localparam int SYM_W    = 5;
    localparam int DIGIT_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int THR_W    = 8;
    localparam int REL_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LIMIT    = 2'd1;

    // Register reset values
    localparam logic [THR_W-1:0] REPEAT_THRESHOLD_RST = 8'd3;
    localparam logic [REL_W-1:0] RELEASE_LIMIT_RST    = 16'd100;

    // Signature and key bit masks
    localparam logic [7:0] MASK_82 = 8'h82;
    localparam logic [7:0] MASK_08 = 8'h08;
    localparam logic [7:0] MASK_20 = 8'h20;
    localparam logic [7:0] MASK_10 = 8'h10;
    localparam logic [7:0] MASK_40 = 8'h40;

    // Symbol codes
    localparam logic [SYM_W-1:0] NO_KEY = 5'd16;

    // Counter limits
    localparam logic [THR_W-1:0] PRESS_MAX   = 8'hFF;
    localparam logic [REL_W-1:0] RELEASE_MAX = 16'hFFFF;

    // Record types
    localparam logic REC_STATUS = 1'b0;
    localparam logic REC_DIGIT  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;      // take the input word and load its status word
        logic load_digit;  // load the next buffered digit into the output
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;    // output register empty or being taken
        logic flush;       // the offered frame flushes the buffer
        logic drain_last;  // current digit is the last of the command
    } dp_status_t;

    // Map the four masked key bits to a key code
    function automatic logic [DIGIT_W-1:0] key_of_bits(input logic [3:0] idx);
        logic [DIGIT_W-1:0] k;
        case (idx)
            4'd0:    k = 4'd1;
            4'd1:    k = 4'd4;
            4'd2:    k = 4'd7;
            4'd3:    k = 4'd14;
            4'd4:    k = 4'd2;
            4'd5:    k = 4'd5;
            4'd6:    k = 4'd8;
            4'd7:    k = 4'd0;
            4'd8:    k = 4'd3;
            4'd9:    k = 4'd6;
            4'd10:   k = 4'd9;
            4'd11:   k = 4'd15;
            4'd12:   k = 4'd10;
            4'd13:   k = 4'd11;
            4'd14:   k = 4'd12;
            4'd15:   k = 4'd13;
            default: k = 4'd0;
        endcase
        return k;
    endfunction

endpackage

/* rtl/voice_frame_dtmf_key_detector.sv */
// ----------------------------------------------------------------------------
// voice_frame_dtmf_key_detector: key tone detector for coded voice frames
// Finds key tone frames, captures one digit per key press and sends the
// collected digits out as a command.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one 9-byte voice frame per word, tlast set on the
//   frame that ends the transmission. Output stream m_axis: one status word
//   per frame (tuser 0), followed, when the frame flushes the buffer, by one
//   word per buffered digit (tuser 1); tlast marks the final word of a frame.
//   Configuration: cfg_we writes cfg_data into the register at cfg_index
//   (0 repeat threshold, 1 release limit); write only while idle.
//   Status word: registered, valid in the cycle after the frame is taken.
//   Throughput: a flushing frame holds off input until its status and digit
//   words are loaded; other frames go one per cycle unless stalled. The rate
//   is set by the single output register, one word per cycle unless stalled.
//   Reset: counters clear, the threshold returns to 3 and the release limit
//   to 100; the digit buffer holds no digits.
//   Stall: when m_axis_tready is low, the output word holds and s_axis_tready
//   drops until the word is taken.
// ----------------------------------------------------------------------------
module voice_frame_dtmf_key_detector
#(
    parameter int MAX_DIGITS = vfdk_pkg::MAX_DIGITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] frame_head, [71:32] frame_tail
    input  logic [vfdk_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] tone_present, [5:1] symbol, [6] digit_captured, [7] overflowed,
    // [11:8] command_digit, [15:12] zero
    output logic [vfdk_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] record_type
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                cfg_we,
    input  logic [vfdk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vfdk_pkg::CFG_W-1:0]          cfg_data
);

    vfdk_pkg::ctrl_cmd_t  cmd;
    vfdk_pkg::dp_status_t status;

    // Sequencer
    vfdk_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // Decode, tracking and output
    vfdk_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* rtl/vfdk_ctrl.sv */
// ----------------------------------------------------------------------------
// vfdk_ctrl: sequencer of the voice frame key detector
// Accepts frames while idle and walks the buffered digits out one word at a
// time when a frame flushes the command buffer.
// ----------------------------------------------------------------------------
module vfdk_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  vfdk_pkg::dp_status_t   status,
    output vfdk_pkg::ctrl_cmd_t    cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic state_reg;
    logic state_next;

    // Take a frame only while idle and the output register can be loaded
    assign s_axis_tready  = (state_reg == ST_IDLE) && status.out_free;
    assign cmd.accept     = s_axis_tready && s_axis_tvalid;
    assign cmd.load_digit = (state_reg == ST_DRAIN) && status.out_free;

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && status.flush)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (cmd.load_digit && status.drain_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/vfdk_datapath.sv */
// ----------------------------------------------------------------------------
// vfdk_datapath: frame decode, press tracking and digit buffer
// Decodes the tone signature and key, keeps the press and release counters,
// stores captured digits and drives the output register.
// ----------------------------------------------------------------------------
module vfdk_datapath
#(
    parameter int MAX_DIGITS = vfdk_pkg::MAX_DIGITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [vfdk_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,
    input  logic                                m_axis_tready,
    input  logic                                cfg_we,
    input  logic [vfdk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vfdk_pkg::CFG_W-1:0]          cfg_data,
    input  vfdk_pkg::ctrl_cmd_t                 cmd,
    output vfdk_pkg::dp_status_t                status,
    output logic                                m_axis_tvalid,
    output logic [vfdk_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);

    localparam int CAPACITY = (MAX_DIGITS > vfdk_pkg::STORE_DEPTH) ?
                              vfdk_pkg::STORE_DEPTH : MAX_DIGITS;
    localparam logic [vfdk_pkg::COUNT_W-1:0] CAP_LIMIT = vfdk_pkg::COUNT_W'(CAPACITY);

    // Configuration registers
    logic [vfdk_pkg::THR_W-1:0]  repeat_threshold_reg;
    logic [vfdk_pkg::REL_W-1:0]  release_limit_reg;

    // Press tracking state
    logic [vfdk_pkg::SYM_W-1:0]   last_symbol_reg,   last_symbol_next;
    logic [vfdk_pkg::THR_W-1:0]   press_count_reg,   press_count_next;
    logic [vfdk_pkg::REL_W-1:0]   release_count_reg, release_count_next;
    logic                         key_held_reg,      key_held_next;
    logic [vfdk_pkg::COUNT_W-1:0] digit_count_reg,   digit_count_next;

    // Digit buffer and drain pointer
    logic [vfdk_pkg::DIGIT_W-1:0]  digit_store_reg [vfdk_pkg::STORE_DEPTH];
    logic [vfdk_pkg::STORE_AW-1:0] drain_idx_reg,  drain_idx_next;
    logic [vfdk_pkg::COUNT_W-1:0]  drain_cnt_reg,  drain_cnt_next;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    logic                         out_type_reg;
    logic                         out_tone_reg;
    logic [vfdk_pkg::SYM_W-1:0]   out_symbol_reg;
    logic                         out_cap_reg;
    logic                         out_ovf_reg;
    logic [vfdk_pkg::DIGIT_W-1:0] out_digit_reg;
    logic                         out_last_reg;

    // Frame decode
    logic [7:0] b0, b1, b2, b3, b4, b5, b6, b7, b8;
    logic       sig;
    logic       tone;
    logic [3:0] key_idx;
    logic [vfdk_pkg::SYM_W-1:0] sym;
    logic       same_key;
    logic [vfdk_pkg::THR_W-1:0] press_count_tone;
    logic       try_capture;
    logic       room;
    logic       cap;
    logic       ovf;
    logic       flush;
    logic [vfdk_pkg::REL_W-1:0] release_base;

    assign b0 = s_axis_tdata[31:24];
    assign b1 = s_axis_tdata[23:16];
    assign b2 = s_axis_tdata[15:8];
    assign b3 = s_axis_tdata[7:0];
    assign b4 = s_axis_tdata[71:64];
    assign b5 = s_axis_tdata[63:56];
    assign b6 = s_axis_tdata[55:48];
    assign b7 = s_axis_tdata[47:40];
    assign b8 = s_axis_tdata[39:32];

    // Match the masked signature bytes
    assign sig = ((b0 & vfdk_pkg::MASK_82) == vfdk_pkg::MASK_82) &&
                 ((b1 & vfdk_pkg::MASK_08) == vfdk_pkg::MASK_08) &&
                 ((b2 & vfdk_pkg::MASK_20) == vfdk_pkg::MASK_20) &&
                 ((b3 & vfdk_pkg::MASK_82) == vfdk_pkg::MASK_82) &&
                 ((b6 & vfdk_pkg::MASK_82) == 8'h00);
    assign tone = sig && !s_axis_tlast;

    assign key_idx = {|(b4 & vfdk_pkg::MASK_10), |(b5 & vfdk_pkg::MASK_40),
                      |(b7 & vfdk_pkg::MASK_08), |(b8 & vfdk_pkg::MASK_20)};
    assign sym     = {1'b0, vfdk_pkg::key_of_bits(key_idx)};

    // Press count after a tone frame: advance on the same key, restart on a new one
    assign same_key         = (sym == last_symbol_reg);
    assign press_count_tone = !same_key ? '0 :
                              (press_count_reg == vfdk_pkg::PRESS_MAX) ? press_count_reg :
                              press_count_reg + 8'd1;

    assign room        = (digit_count_reg < CAP_LIMIT);
    assign try_capture = !key_held_reg && (press_count_tone >= repeat_threshold_reg);
    assign cap         = tone && try_capture && room;
    assign ovf         = tone && try_capture && !room;
    assign flush       = !tone && (s_axis_tlast || (release_count_reg >= release_limit_reg))
                         && (digit_count_reg != '0);

    assign status.out_free   = !out_valid_reg || m_axis_tready;
    assign status.flush      = flush;
    assign status.drain_last = ({1'b0, drain_idx_reg} + 5'd1) == drain_cnt_reg;

    // Update press tracking on each accepted frame and the drain pointer on each digit load
    always_comb
    begin
        last_symbol_next   = last_symbol_reg;
        press_count_next   = press_count_reg;
        release_count_next = release_count_reg;
        key_held_next      = key_held_reg;
        digit_count_next   = digit_count_reg;
        drain_idx_next     = drain_idx_reg;
        drain_cnt_next     = drain_cnt_reg;
        release_base       = flush ? '0 : release_count_reg;

        if (cmd.accept)
        begin
            if (tone)
            begin
                last_symbol_next = sym;
                press_count_next = press_count_tone;
                if (try_capture)
                begin
                    release_count_next = '0;
                    key_held_next      = 1'b1;
                    if (room)
                    begin
                        digit_count_next = digit_count_reg + 5'd1;
                    end
                end
            end
            else
            begin
                if (flush)
                begin
                    digit_count_next = '0;
                    drain_idx_next   = '0;
                    drain_cnt_next   = digit_count_reg;
                end
                key_held_next    = 1'b0;
                press_count_next = '0;
                last_symbol_next = vfdk_pkg::NO_KEY;
                if (release_base != vfdk_pkg::RELEASE_MAX)
                begin
                    release_count_next = release_base + 16'd1;
                end
                else
                begin
                    release_count_next = release_base;
                end
            end
        end

        if (cmd.load_digit)
        begin
            drain_idx_next = drain_idx_reg + 4'd1;
        end
    end

    // Hold output valid until the word is taken
    always_comb
    begin
        if (cmd.accept || cmd.load_digit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_threshold_reg <= vfdk_pkg::REPEAT_THRESHOLD_RST;
            release_limit_reg    <= vfdk_pkg::RELEASE_LIMIT_RST;
            last_symbol_reg      <= vfdk_pkg::NO_KEY;
            press_count_reg      <= '0;
            release_count_reg    <= '0;
            key_held_reg         <= 1'b0;
            digit_count_reg      <= '0;
            drain_idx_reg        <= '0;
            drain_cnt_reg        <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == vfdk_pkg::CFG_REPEAT_THRESHOLD))
            begin
                repeat_threshold_reg <= cfg_data[vfdk_pkg::THR_W-1:0];
            end
            if (cfg_we && (cfg_index == vfdk_pkg::CFG_RELEASE_LIMIT))
            begin
                release_limit_reg <= cfg_data[vfdk_pkg::REL_W-1:0];
            end
            last_symbol_reg   <= last_symbol_next;
            press_count_reg   <= press_count_next;
            release_count_reg <= release_count_next;
            key_held_reg      <= key_held_next;
            digit_count_reg   <= digit_count_next;
            drain_idx_reg     <= drain_idx_next;
            drain_cnt_reg     <= drain_cnt_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Append a captured key to the buffer
    always_ff @(posedge clk)
    begin
        if (cmd.accept && cap)
        begin
            digit_store_reg[digit_count_reg[vfdk_pkg::STORE_AW-1:0]] <= sym[vfdk_pkg::DIGIT_W-1:0];
        end
    end

    // Load the output word: status for a frame, or the next buffered digit
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            out_type_reg   <= vfdk_pkg::REC_STATUS;
            out_tone_reg   <= tone;
            out_symbol_reg <= tone ? sym : vfdk_pkg::NO_KEY;
            out_cap_reg    <= cap;
            out_ovf_reg    <= ovf;
            out_digit_reg  <= '0;
            out_last_reg   <= !flush;
        end
        else if (cmd.load_digit)
        begin
            out_type_reg   <= vfdk_pkg::REC_DIGIT;
            out_tone_reg   <= 1'b0;
            out_symbol_reg <= vfdk_pkg::NO_KEY;
            out_cap_reg    <= 1'b0;
            out_ovf_reg    <= 1'b0;
            out_digit_reg  <= digit_store_reg[drain_idx_reg];
            out_last_reg   <= status.drain_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_type_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {4'b0000, out_digit_reg, out_ovf_reg, out_cap_reg,
                            out_symbol_reg, out_tone_reg};

    // Buffer never holds more digits than its capacity
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= CAP_LIMIT)
        else $error("digit count exceeds buffer capacity");

    // A new output word is loaded only into a free output register
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept || cmd.load_digit) |-> (!out_valid_reg || m_axis_tready))
        else $error("output word overwritten before it was taken");

    // Frame intake and digit drain never happen together
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.accept && cmd.load_digit))
        else $error("frame accepted during digit drain");

    // A drain only walks a non-empty command
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_digit |-> (drain_cnt_reg != '0) && ({1'b0, drain_idx_reg} < drain_cnt_reg))
        else $error("digit drain outside buffered command");

endmodule

/* verif/tb_voice_frame_dtmf_key_detector.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voice_frame_dtmf_key_detector: self-checking bench for the key detector
// Drives coded voice frames into the slave stream and tracks the detector
// state in a bench-side key tracker. Every status and command digit word on
// the master stream is checked against it. The run starts with a table of
// directed frames. Random phases follow, each with its own register
// settings and its own idle and stall pattern.
// ----------------------------------------------------------------------------
module tb_voice_frame_dtmf_key_detector;

    localparam int BUF_CAP        = (vfdk_pkg::MAX_DIGITS > vfdk_pkg::STORE_DEPTH) ?
                                    vfdk_pkg::STORE_DEPTH : vfdk_pkg::MAX_DIGITS;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 24;    // a full 17-word flush plus margin
    // Longest correct stretch without a word moved is the hold-off plus a
    // settle; take it many times over
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    // Register indexes with no register behind them
    localparam logic [vfdk_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [vfdk_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Signature bits forced in a tone frame head, and the tail bits that
    // carry the key or must stay clear
    localparam logic [31:0] SIG_HEAD        = 32'h8208_2082;
    localparam logic [39:0] TAIL_KEYED_BITS = 40'h10_40_82_08_20;

    // Key codes by masked key bits, index 0 in the lowest nibble
    localparam logic [63:0] KEY_CODES = {4'd13, 4'd12, 4'd11, 4'd10, 4'd15, 4'd9, 4'd6, 4'd3,
                                         4'd0,  4'd8,  4'd5,  4'd2,  4'd14, 4'd7, 4'd4, 4'd1};

    typedef struct packed {
        logic                         record_type;
        logic                         tone_present;
        logic [vfdk_pkg::SYM_W-1:0]   symbol;
        logic                         digit_captured;
        logic                         overflowed;
        logic [vfdk_pkg::DIGIT_W-1:0] command_digit;
        logic                         last;
    } key_word_t;

    typedef struct packed {
        logic [vfdk_pkg::HEAD_W-1:0] head;
        logic [vfdk_pkg::TAIL_W-1:0] tail;
        logic                        eos;
        logic                        typed;
        key_word_t                   word;
    } frame_row_t;

    localparam key_word_t IDLE_STATUS = '{record_type: vfdk_pkg::REC_STATUS,
                                          tone_present: 1'b0,
                                          symbol: vfdk_pkg::NO_KEY, digit_captured: 1'b0,
                                          overflowed: 1'b0, command_digit: 4'd0, last: 1'b1};

    // DUT ports
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [vfdk_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [vfdk_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;
    logic                            cfg_we = 1'b0;
    logic [vfdk_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [vfdk_pkg::CFG_W-1:0]      cfg_data = '0;

    // Key tracker state and register copies
    logic [vfdk_pkg::THR_W-1:0]   repeat_thr;
    logic [vfdk_pkg::REL_W-1:0]   release_lim;
    logic [vfdk_pkg::SYM_W-1:0]   last_key;
    logic [vfdk_pkg::THR_W-1:0]   press_run;
    logic [vfdk_pkg::REL_W-1:0]   quiet_run;
    logic                         key_held;
    logic [vfdk_pkg::DIGIT_W-1:0] digit_buf [vfdk_pkg::STORE_DEPTH];
    int                           digit_cnt;

    key_word_t  expected_words[$];
    frame_row_t frame_table[$];

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;

    int frames_sent   = 0;
    int words_checked = 0;
    int digit_words   = 0;
    int captures      = 0;
    int drops         = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    voice_frame_dtmf_key_detector dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Key tracker
    // ------------------------------------------------------------------

    // Advance the tracker by one frame and queue the words it causes
    function automatic void predict_frame(input logic [vfdk_pkg::HEAD_W-1:0] head,
                                          input logic [vfdk_pkg::TAIL_W-1:0] tail,
                                          input logic eos);
        logic       sig;
        logic [3:0] idx;
        logic [vfdk_pkg::SYM_W-1:0] sym;
        logic       flush;
        key_word_t  w;
        int         j;
        sig = ((head[31:24] & vfdk_pkg::MASK_82) == vfdk_pkg::MASK_82) &&
              ((head[23:16] & vfdk_pkg::MASK_08) == vfdk_pkg::MASK_08) &&
              ((head[15:8] & vfdk_pkg::MASK_20) == vfdk_pkg::MASK_20) &&
              ((head[7:0] & vfdk_pkg::MASK_82) == vfdk_pkg::MASK_82) &&
              ((tail[23:16] & vfdk_pkg::MASK_82) == 8'h00);
        w = IDLE_STATUS;
        if (!eos && sig)
        begin
            idx = {|(tail[39:32] & vfdk_pkg::MASK_10), |(tail[31:24] & vfdk_pkg::MASK_40),
                   |(tail[15:8] & vfdk_pkg::MASK_08), |(tail[7:0] & vfdk_pkg::MASK_20)};
            sym = {1'b0, KEY_CODES[idx*4 +: 4]};
            // count repeats of the same key, restart on a new one
            if (sym == last_key)
            begin
                if (press_run != vfdk_pkg::PRESS_MAX)
                    press_run = press_run + 1'b1;
            end
            else
            begin
                last_key  = sym;
                press_run = '0;
            end
            // capture once per press; a full buffer drops the key
            if (!key_held && press_run >= repeat_thr)
            begin
                if (digit_cnt < BUF_CAP)
                begin
                    digit_buf[digit_cnt] = sym[vfdk_pkg::DIGIT_W-1:0];
                    digit_cnt = digit_cnt + 1;
                    w.digit_captured = 1'b1;
                end
                else
                begin
                    w.overflowed = 1'b1;
                end
                quiet_run = '0;
                key_held  = 1'b1;
            end
            w.tone_present = 1'b1;
            w.symbol       = sym;
            expected_words.push_back(w);
        end
        else
        begin
            flush = (eos || quiet_run >= release_lim) && digit_cnt != 0;
            w.last = !flush;
            expected_words.push_back(w);
            // send the buffered command, oldest digit first
            if (flush)
            begin
                for (j = 0; j < digit_cnt; j++)
                begin
                    w = IDLE_STATUS;
                    w.record_type   = vfdk_pkg::REC_DIGIT;
                    w.command_digit = digit_buf[j];
                    w.last          = (j == digit_cnt - 1);
                    expected_words.push_back(w);
                end
                digit_cnt = 0;
                quiet_run = '0;
            end
            key_held = 1'b0;
            if (quiet_run != vfdk_pkg::RELEASE_MAX)
                quiet_run = quiet_run + 1'b1;
            press_run = '0;
            last_key  = vfdk_pkg::NO_KEY;
        end
    endfunction

    // ------------------------------------------------------------------
    // Frame builders
    // ------------------------------------------------------------------

    function automatic logic [vfdk_pkg::TAIL_W-1:0] rand_tail();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[vfdk_pkg::TAIL_W-1:0];
    endfunction

    // Tail carrying a key, random bits elsewhere, signature byte clear
    function automatic logic [vfdk_pkg::TAIL_W-1:0] tone_tail(
        input logic [3:0] key,
        input logic [vfdk_pkg::TAIL_W-1:0] fill);
        logic [vfdk_pkg::TAIL_W-1:0] t;
        t = fill & ~TAIL_KEYED_BITS;
        t[36] = key[3];
        t[30] = key[2];
        t[11] = key[1];
        t[5]  = key[0];
        return t;
    endfunction

    function automatic key_word_t tone_status(input logic [vfdk_pkg::SYM_W-1:0] sym,
                                              input logic cap);
        key_word_t w;
        w = IDLE_STATUS;
        w.tone_present   = 1'b1;
        w.symbol         = sym;
        w.digit_captured = cap;
        return w;
    endfunction

    task automatic add_row(input logic [vfdk_pkg::HEAD_W-1:0] head,
                           input logic [vfdk_pkg::TAIL_W-1:0] tail,
                           input logic eos, input logic typed, input key_word_t word);
        frame_row_t r;
        r.head  = head;
        r.tail  = tail;
        r.eos   = eos;
        r.typed = typed;
        r.word  = word;
        frame_table.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one frame, idling first at the sender's rate, until taken
    task automatic offer_frame(input logic [vfdk_pkg::HEAD_W-1:0] head,
                               input logic [vfdk_pkg::TAIL_W-1:0] tail,
                               input logic eos);
        while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tail, head};
        s_axis_tlast  <= eos;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        frames_sent++;
    endtask

    task automatic send_frame(input logic [vfdk_pkg::HEAD_W-1:0] head,
                              input logic [vfdk_pkg::TAIL_W-1:0] tail,
                              input logic eos);
        offer_frame(head, tail, eos);
        predict_frame(head, tail, eos);
    endtask

    // Quiet frame: byte 0 top bit clear, so never a tone frame
    task automatic send_quiet(input logic eos);
        logic [vfdk_pkg::HEAD_W-1:0] h;
        h = $urandom;
        h[31] = 1'b0;
        send_frame(h, rand_tail(), eos);
    endtask

    // Stop offering, drain every expected word, then let the block go idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; only called while idle
    task automatic cfg_write(input logic [vfdk_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vfdk_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == vfdk_pkg::CFG_REPEAT_THRESHOLD)
            repeat_thr = val[vfdk_pkg::THR_W-1:0];
        else if (idx == vfdk_pkg::CFG_RELEASE_LIMIT)
            release_lim = val[vfdk_pkg::REL_W-1:0];
    endtask

    // Mostly well-formed key presses with random content, plus noise and
    // frames with a damaged signature
    task automatic random_traffic(input int n_frames);
        int start;
        int pick;
        int reps;
        int gaps;
        int k;
        logic [3:0] key;
        logic eos;
        logic [vfdk_pkg::HEAD_W-1:0] h;
        logic [vfdk_pkg::TAIL_W-1:0] t;
        start = frames_sent;
        while (frames_sent - start < n_frames)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                // one press, then a release that sometimes runs past the limit
                key  = 4'($urandom_range(15));
                reps = int'($urandom_range(int'(repeat_thr) + 2, 1));
                if (reps > 12)
                    reps = 12;
                for (k = 0; k < reps; k++)
                    send_frame($urandom | SIG_HEAD, tone_tail(key, rand_tail()), 1'b0);
                if ($urandom_range(9) == 0)
                    gaps = (release_lim > 20) ? 22 : int'(release_lim) + 2;
                else
                    gaps = $urandom_range(3, 1);
                for (k = 0; k < gaps; k++)
                begin
                    eos = (k == gaps - 1) && ($urandom_range(6) == 0);
                    if (eos && $urandom_range(1) == 1)
                        send_frame($urandom | SIG_HEAD, tone_tail(4'($urandom), rand_tail()),
                                   1'b1);
                    else
                        send_quiet(eos);
                end
            end
            else if (pick < 85)
            begin
                send_frame($urandom, rand_tail(), 1'($urandom_range(1)));
            end
            else
            begin
                // tone frame with one signature bit broken
                h = $urandom | SIG_HEAD;
                t = tone_tail(4'($urandom), rand_tail());
                case ($urandom_range(7))
                    0: h[31] = 1'b0;
                    1: h[25] = 1'b0;
                    2: h[19] = 1'b0;
                    3: h[13] = 1'b0;
                    4: h[7]  = 1'b0;
                    5: h[1]  = 1'b0;
                    6: t[23] = 1'b1;
                    default: t[17] = 1'b1;
                endcase
                send_frame(h, t, 1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, and a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        key_word_t got;
        key_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.record_type    = m_axis_tuser;
            got.tone_present   = m_axis_tdata[0];
            got.symbol         = m_axis_tdata[5:1];
            got.digit_captured = m_axis_tdata[6];
            got.overflowed     = m_axis_tdata[7];
            got.command_digit  = m_axis_tdata[11:8];
            got.last           = m_axis_tlast;
            words_checked++;
            if (got.record_type == vfdk_pkg::REC_DIGIT)
                digit_words++;
            if (got.digit_captured)
                captures++;
            if (got.overflowed)
                drops++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected word tdata %h tuser %b tlast %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = expected_words.pop_front();
                if (got !== want || m_axis_tdata[15:12] !== 4'h0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: word mismatch (type tone sym cap ovf digit last pad)",
                                 $time);
                        $display("    exp %0d %0d %0d %0d %0d %0d %0d 0",
                                 want.record_type, want.tone_present, want.symbol,
                                 want.digit_captured, want.overflowed, want.command_digit,
                                 want.last);
                        $display("    got %0d %0d %0d %0d %0d %0d %0d %0h",
                                 got.record_type, got.tone_present, got.symbol,
                                 got.digit_captured, got.overflowed, got.command_digit,
                                 got.last, m_axis_tdata[15:12]);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles, %0d words still expected",
                     $time, WATCHDOG_LIMIT, expected_words.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int r;
        int k;
        int n0;
        logic [3:0] key;

        // tracker reset values
        repeat_thr  = vfdk_pkg::REPEAT_THRESHOLD_RST;
        release_lim = vfdk_pkg::RELEASE_LIMIT_RST;
        last_key    = vfdk_pkg::NO_KEY;
        press_run   = '0;
        quiet_run   = '0;
        key_held    = 1'b0;
        digit_cnt   = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at reset settings (threshold 3, release limit 100)
        add_row('0, '0, 1'b0, 1'b1, IDLE_STATUS);
        add_row('1, '1, 1'b0, 1'b1, IDLE_STATUS);                 // byte 6 bits set
        add_row('1, '1, 1'b1, 1'b1, IDLE_STATUS);                 // end, nothing buffered
        add_row(SIG_HEAD, tone_tail(4'd0, '0), 1'b0, 1'b1, tone_status(5'd1, 1'b0));
        add_row(SIG_HEAD, tone_tail(4'd0, '0), 1'b0, 1'b0, IDLE_STATUS);
        add_row(SIG_HEAD, tone_tail(4'd0, '0), 1'b0, 1'b0, IDLE_STATUS);
        add_row(SIG_HEAD, tone_tail(4'd0, '0), 1'b0, 1'b1, tone_status(5'd1, 1'b1));
        add_row(SIG_HEAD, tone_tail(4'd0, '0), 1'b0, 1'b1, tone_status(5'd1, 1'b0)); // held
        add_row('1, tone_tail(4'd15, '1), 1'b0, 1'b0, IDLE_STATUS); // new key while held
        add_row(32'hFFF7_FFFF, tone_tail(4'd15, '1), 1'b0, 1'b0, IDLE_STATUS); // broken sig
        for (k = 0; k < 4; k++)
            add_row('1, tone_tail(4'd15, '1), 1'b0, 1'b0, IDLE_STATUS);
        add_row(SIG_HEAD, tone_tail(4'd6, '0), 1'b1, 1'b0, IDLE_STATUS); // tone with end
        add_row('0, '0, 1'b1, 1'b1, IDLE_STATUS);
        add_row(SIG_HEAD, tone_tail(4'd3, '0), 1'b0, 1'b1, tone_status(5'd14, 1'b0));
        add_row(SIG_HEAD, tone_tail(4'd7, '0), 1'b0, 1'b1, tone_status(5'd0, 1'b0));
        add_row(SIG_HEAD, tone_tail(4'd11, '0), 1'b0, 1'b1, tone_status(5'd15, 1'b0));
        add_row(SIG_HEAD, tone_tail(4'd12, '0), 1'b0, 1'b1, tone_status(5'd10, 1'b0));
        add_row('0, '1, 1'b1, 1'b0, IDLE_STATUS);

        foreach (frame_table[i])
        begin
            offer_frame(frame_table[i].head, frame_table[i].tail, frame_table[i].eos);
            n0 = expected_words.size();
            predict_frame(frame_table[i].head, frame_table[i].tail, frame_table[i].eos);
            if (frame_table[i].typed)
                expected_words[n0] = frame_table[i].word;
        end
        settle();

        // Zero threshold, zero release limit; sender mostly idle
        cfg_write(vfdk_pkg::CFG_REPEAT_THRESHOLD, 16'd0);
        cfg_write(vfdk_pkg::CFG_RELEASE_LIMIT, 16'd0);
        snd_idle_pct = 88;
        random_traffic(20);
        send_quiet(1'b1);
        settle();

        // Threshold 255 and release limit 65535: one very long press under a
        // long receiver hold-off, so the block backs up into the input
        cfg_write(vfdk_pkg::CFG_REPEAT_THRESHOLD, 16'hFFFF);
        cfg_write(vfdk_pkg::CFG_RELEASE_LIMIT, 16'hFFFF);
        cfg_write(CFG_SPARE_A, vfdk_pkg::CFG_W'($urandom));
        snd_idle_pct = 0;
        hold_req = 1'b1;
        key = 4'($urandom);
        for (k = 0; k < 258; k++)
            send_frame($urandom | SIG_HEAD, tone_tail(key, rand_tail()), 1'b0);
        send_quiet(1'b1);
        settle();

        // Threshold 1: capture past a full buffer, then flush it all at once;
        // receiver stalling
        cfg_write(vfdk_pkg::CFG_REPEAT_THRESHOLD, 16'd1);
        cfg_write(vfdk_pkg::CFG_RELEASE_LIMIT, 16'd3);
        rcv_stall_pct = 88;
        for (r = 0; r < BUF_CAP + 3; r++)
        begin
            key = 4'($urandom);
            send_frame($urandom | SIG_HEAD, tone_tail(key, rand_tail()), 1'b0);
            send_frame($urandom | SIG_HEAD, tone_tail(key, rand_tail()), 1'b0);
            send_quiet(1'b0);
        end
        send_quiet(1'b1);
        random_traffic(10);
        send_quiet(1'b1);
        settle();

        // Small random settings; both sides idling, with a full drain midway
        cfg_write(vfdk_pkg::CFG_REPEAT_THRESHOLD, vfdk_pkg::CFG_W'($urandom_range(5)));
        cfg_write(vfdk_pkg::CFG_RELEASE_LIMIT, vfdk_pkg::CFG_W'($urandom_range(8)));
        cfg_write(CFG_SPARE_B, vfdk_pkg::CFG_W'($urandom));
        snd_idle_pct  = 35;
        rcv_stall_pct = 35;
        random_traffic(10);
        settle();
        random_traffic(10);
        send_quiet(1'b1);
        settle();

        // Back to near-default settings, no idling
        cfg_write(vfdk_pkg::CFG_REPEAT_THRESHOLD, 16'hAA02);
        cfg_write(vfdk_pkg::CFG_RELEASE_LIMIT, 16'd100);
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        random_traffic(10);
        send_quiet(1'b1);
        settle();

        $display("covered %0d frames, %0d result words checked, %0d of them command digits",
                 frames_sent, words_checked, digit_words);
        $display("keys captured %0d, keys dropped on a full buffer %0d, mismatches %0d",
                 captures, drops, mismatches);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
